@@ rtl/core/hmap_pkg.sv @@
`default_nettype none

package hmap_pkg;

    // Table geometry
    localparam int BUCKETS      = 64;
    localparam int POOL_ENTRIES = 256;
    localparam int HASH_SHIFT   = 3;

    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int NODE_W = $clog2(POOL_ENTRIES);
    localparam int CNT_W  = NODE_W + 1;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_CLEAR  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_HEAD,
        S_NODE,
        S_DONE
    } state_t;

    // One pool node as stored in the node memory
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic              link_vld;
        logic [NODE_W-1:0] link;
    } node_t;

endpackage

`default_nettype wire

@@ rtl/core/hmap_if.sv @@
`default_nettype none

// Request channel: one operation on the table
interface hmap_req_if
    import hmap_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, mode, key, value, input ready);
    modport sink   (input valid, mode, key, value, output ready);
endinterface

// Response channel: one answer per request
interface hmap_rsp_if
    import hmap_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;

    modport source (output valid, status, found_value, input ready);
    modport sink   (input valid, status, found_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hmap_ram.sv @@
`default_nettype none

module hmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on we, registered read of the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

@@ rtl/core/address_keyed_hash_map_unit.sv @@
// Hash map keyed by 64-bit addresses with separate chaining over a fixed pool
// of 256 nodes and 64 buckets (bucket = key bits [8:3]). A request carries a
// mode: search walks the bucket chain to the most recently inserted matching
// key and answers status 0 with its value, or status 1 on a miss; insert
// pushes a new node at the head of its bucket without a duplicate check and
// answers status 0, or status 2 when all 256 nodes are in use; clear empties
// the table at once and answers status 0; mode 3 does nothing and answers 0.
// found_value is zero except on a search hit. One request is worked at a time
// and the next is accepted once the answer sits in the output register, even
// if it has not been taken yet. Clear, mode 3, a refused insert and a search
// that finds its bucket empty answer straight after the bucket lookup; an
// insert reads the bucket head and then pushes its node; a search reads the
// head and then visits the chain node by node. The chain walk sets the rate:
// each node visited costs one registered read of the node memory.
`default_nettype none

module address_keyed_hash_map_unit
    import hmap_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    hmap_req_if.sink   req,
    hmap_rsp_if.source rsp
);

    state_t            state_reg, state_next;
    logic [1:0]        mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [BUCKETS-1:0] hv_reg, hv_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    status_t           res_status_reg, res_status_next;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;

    logic              rsp_valid_reg;
    logic [1:0]        rsp_status_reg;
    logic [VAL_W-1:0]  rsp_value_reg;

    logic [BKT_W-1:0]  bkt;
    logic              head_we;
    logic [NODE_W-1:0] head_wdata;
    logic [NODE_W-1:0] head_rdata;
    logic              node_we;
    logic [NODE_W-1:0] node_addr;
    node_t             node_wdata;
    node_t             node_rdata;
    logic              out_load;
    logic              req_fire;

    assign bkt      = key_reg[HASH_SHIFT +: BKT_W];
    assign req_fire = req.valid && req.ready;

    // Bucket heads: node index per bucket; valid bits live in hv_reg
    hmap_ram #(
        .WIDTH (NODE_W),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .addr  (bkt),
        .wdata (head_wdata),
        .rdata (head_rdata)
    );

    // Pool nodes: key, value and next link
    hmap_ram #(
        .WIDTH ($bits(node_t)),
        .DEPTH (POOL_ENTRIES)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .addr  (node_addr),
        .wdata (node_wdata),
        .rdata (node_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hv_reg        <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hv_reg    <= hv_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            mode_reg  <= req.mode;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (out_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_value_reg  <= res_value_reg;
        end
    end

    // Sequencer: look up bucket, read head, walk or push, then post the answer
    always_comb
    begin
        state_next      = state_reg;
        hv_next         = hv_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        head_we         = 1'b0;
        head_wdata      = cnt_reg[NODE_W-1:0];
        node_we         = 1'b0;
        node_addr       = head_rdata;
        node_wdata      = '{key: key_reg, value: value_reg,
                            link_vld: hv_reg[bkt], link: head_rdata};
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                res_status_next = ST_OK;
                res_value_next  = '0;
                case (mode_reg)
                    MODE_SEARCH:
                    begin
                        if (hv_reg[bkt])
                        begin
                            state_next = S_HEAD;
                        end
                        else
                        begin
                            res_status_next = ST_MISS;
                            state_next      = S_DONE;
                        end
                    end
                    MODE_INSERT:
                    begin
                        if (cnt_reg == CNT_W'(POOL_ENTRIES))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_HEAD;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        hv_next    = '0;
                        cnt_next   = '0;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_HEAD:
            begin
                if (mode_reg == MODE_INSERT)
                begin
                    // Push the new node at the chain head
                    node_we      = 1'b1;
                    node_addr    = cnt_reg[NODE_W-1:0];
                    head_we      = 1'b1;
                    hv_next[bkt] = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    state_next   = S_DONE;
                end
                else
                begin
                    node_addr  = head_rdata;
                    state_next = S_NODE;
                end
            end

            S_NODE:
            begin
                if (node_rdata.key == key_reg)
                begin
                    res_value_next = node_rdata.value;
                    state_next     = S_DONE;
                end
                else if (node_rdata.link_vld)
                begin
                    node_addr = node_rdata.link;
                end
                else
                begin
                    res_status_next = ST_MISS;
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.found_value = rsp_value_reg;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(POOL_ENTRIES))
        else $error("node count beyond pool size");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HEAD && mode_reg == MODE_INSERT)
            |-> (cnt_reg < CNT_W'(POOL_ENTRIES)))
        else $error("insert pushed into a full pool");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_status_reg == ST_FULL)
            |-> (cnt_reg == CNT_W'(POOL_ENTRIES)))
        else $error("full status without a full pool");

    a_value_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_status_reg != ST_OK) |-> (rsp_value_reg == '0))
        else $error("nonzero value on a non-hit answer");

    a_walk_is_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NODE) |-> (mode_reg == MODE_SEARCH))
        else $error("chain walk outside a search");

endmodule

`default_nettype wire
